FILE: rtl/core/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern search block.
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_CFG_W  = 9;
    localparam int RANGE_W    = 32;
    localparam int OFFSET_O_W = 32;
    localparam int CFG_ADDR_W = 2;

    // Input opcodes; the fourth code is ignored.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_DATA  = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] CFG_LEN   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_START = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_END   = 2'd2;

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic              wr;        // pattern entry write this cycle
        logic [BYTE_W-1:0] wr_index;
        logic [BYTE_W-1:0] wr_value;
        logic              wr_care;
        logic              shift;     // data byte transfer this cycle
        logic              flush;     // previous match bits count as zero
        logic [BYTE_W-1:0] data;
    } t_cell_ctl;

    typedef struct packed {
        logic                  found;
        logic [OFFSET_O_W-1:0] match_offset;
        logic                  range_ok;
    } t_result;

endpackage : wbps_pkg

`default_nettype wire

FILE: rtl/core/wbps_cell.sv
// One pattern position: stored entry, byte compare and partial-match bit.
`timescale 1ns / 1ps
`default_nettype none

module wbps_cell #(
    parameter int K  = 0,
    parameter int LW = 8
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire wbps_pkg::t_cell_ctl i_ctl,
    input  wire  [LW-1:0]         i_len_m1,
    input  wire                   i_prev,
    output logic                  o_match
);
    import wbps_pkg::*;

    logic              r_care;
    logic [BYTE_W-1:0] r_value;
    logic              r_match;
    logic              w_wr_hit;
    logic              w_active;
    logic              w_prev;
    logic              w_ok;

    generate
        if (K < (1 << BYTE_W)) begin : g_wr
            assign w_wr_hit = i_ctl.wr && (i_ctl.wr_index == BYTE_W'(K));
        end else begin : g_no_wr
            assign w_wr_hit = 1'b0;
        end
        // The first position always has an open match to extend.
        if (K == 0) begin : g_head
            assign w_prev = i_prev;
        end else begin : g_body
            assign w_prev = i_prev && !i_ctl.flush;
        end
    endgenerate

    assign w_active = (LW'(K) <= i_len_m1);
    assign w_ok     = !r_care || (r_value == i_ctl.data);

    always_ff @(posedge i_clk) begin
        if (w_wr_hit) begin
            r_care  <= i_ctl.wr_care;
            r_value <= i_ctl.wr_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.shift) begin
            if (w_active) begin
                r_match <= w_prev && w_ok;
            end else if (i_ctl.flush) begin
                r_match <= 1'b0;
            end
        end
    end

    assign o_match = r_match;

endmodule : wbps_cell

`default_nettype wire

FILE: rtl/core/wbps_out_buf.sv
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps
`default_nettype none

module wbps_out_buf (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire wbps_pkg::t_result i_data,
    output logic                o_skid_full,
    output logic                o_valid,
    input  wire                 i_ready,
    output wbps_pkg::t_result   o_data
);
    import wbps_pkg::*;

    logic    r_ov;
    logic    r_sv;
    t_result r_out;
    t_result r_skid;
    logic    w_pop;

    assign w_pop = r_ov && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || w_pop) begin
            r_ov <= r_sv || i_push;
            r_sv <= r_sv && i_push;
        end else if (i_push) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || w_pop) begin
            r_out <= r_sv ? r_skid : i_data;
            if (r_sv && i_push) begin
                r_skid <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_skid_full = r_sv;
    assign o_valid     = r_ov;
    assign o_data      = r_out;

endmodule : wbps_out_buf

`default_nettype wire

FILE: rtl/core/wildcard_byte_pattern_search.sv
// Top level of the wildcard byte pattern search: cell row, qualify stage, result buffer.
//
// - Input channel (i_in_valid / o_in_ready), one item per transfer: opcode 0
//   writes pattern entry i_entry_index, 1 starts a new search, 2 streams one
//   data byte (i_data_last marks the final byte), 3 is dropped.
// - Configuration write port (i_cfg_we, i_cfg_addr, i_cfg_wdata): 0 pattern
//   length, 1 range start, 2 range end (zero = end of stream). Write it only
//   while nothing is in flight.
// - Throughput: one item per cycle while o_in_ready is high. Each pattern position
//   has its own cell; all cells compare the byte in its transfer cycle and pass
//   their match bit on. After a byte transfer the qualify stage selects the
//   full-length match bit, qualifies the start offset and, for a last byte, loads
//   the result into the buffer that drives o_out_valid. One result per last byte.
// - Results sit in a two-entry buffer (output plus skid register). A stalled
//   receiver back-pressures the input only once both are full and another last
//   byte waits in the qualify stage.
// - Reset (synchronous, active low) clears the search state and sets length 1,
//   range 0..end of stream. Pattern entries are not cleared; write them first.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_byte_pattern_search #(
    parameter int MAX_PATTERN = 256,
    parameter int OFFSET_BITS = 32
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // configuration write port
    input  wire                                   i_cfg_we,
    input  wire  [wbps_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  wire  [wbps_pkg::RANGE_W-1:0]          i_cfg_wdata,
    // input items
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire  [1:0]                            i_opcode,
    input  wire  [wbps_pkg::BYTE_W-1:0]           i_entry_index,
    input  wire  [wbps_pkg::BYTE_W-1:0]           i_entry_value,
    input  wire                                   i_entry_care,
    input  wire  [wbps_pkg::BYTE_W-1:0]           i_data_byte,
    input  wire                                   i_data_last,
    // results
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic                                  o_found,
    output logic [wbps_pkg::OFFSET_O_W-1:0]       o_match_offset,
    output logic                                  o_range_ok
);
    import wbps_pkg::*;

    // Cell index width, length compare width, offset arithmetic width.
    localparam int LW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CW = ($clog2(MAX_PATTERN + 1) > LEN_CFG_W) ?
                        $clog2(MAX_PATTERN + 1) : LEN_CFG_W;
    localparam int W  = (OFFSET_BITS > RANGE_W) ? OFFSET_BITS : RANGE_W;
    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    // configuration registers
    logic [LEN_CFG_W-1:0] r_cfg_len;
    logic [RANGE_W-1:0]   r_cfg_start;
    logic [RANGE_W-1:0]   r_cfg_end;

    // search state
    logic [OFFSET_BITS-1:0] r_pos;
    logic                   r_flush;
    logic                   r_seen;
    logic [OFFSET_BITS-1:0] r_first;

    // qualify stage
    logic                   r_s1_valid;
    logic                   r_s1_last;
    logic [LW-1:0]          r_s1_len_m1;
    logic [OFFSET_BITS-1:0] r_s1_pos;

    logic                   w_in_fire;
    logic                   w_fire_data;
    logic                   w_fire_start;
    logic [CW-1:0]          w_len_ext;
    logic [CW-1:0]          w_len_m1_ext;
    logic [LW-1:0]          w_len_m1;
    t_cell_ctl              w_ctl;
    logic [MAX_PATTERN-1:0] w_match;
    logic                   w_skid_full;
    logic                   w_s2_go;
    logic                   w_hit;
    logic [W-1:0]           w_pos_w;
    logic [W-1:0]           w_len_w;
    logic [W-1:0]           w_mstart;
    logic                   w_cand;
    logic                   w_rok;
    logic [W-1:0]           w_off_w;
    t_result                w_res;
    t_result                w_out;

    // Stall only when a last byte must load a result and the buffer is full.
    assign o_in_ready   = !(r_s1_valid && r_s1_last && w_skid_full);
    assign w_in_fire    = i_in_valid && o_in_ready;
    assign w_fire_data  = w_in_fire && (i_opcode == OP_DATA);
    assign w_fire_start = w_in_fire && (i_opcode == OP_START);

    // Active length minus one, zero read as one, clamped to the row size.
    assign w_len_ext = CW'(r_cfg_len);
    always_comb begin
        if (w_len_ext == '0) begin
            w_len_m1_ext = '0;
        end else if (w_len_ext > CW'(MAX_PATTERN)) begin
            w_len_m1_ext = CW'(MAX_PATTERN - 1);
        end else begin
            w_len_m1_ext = w_len_ext - CW'(1);
        end
    end
    assign w_len_m1 = w_len_m1_ext[LW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len   <= LEN_CFG_W'(1);
            r_cfg_start <= '0;
            r_cfg_end   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_LEN:   r_cfg_len   <= i_cfg_wdata[LEN_CFG_W-1:0];
                CFG_START: r_cfg_start <= i_cfg_wdata;
                CFG_END:   r_cfg_end   <= i_cfg_wdata;
                default:   ;
            endcase
        end
    end

    // ---------------------------------------------------------------- cell row
    assign w_ctl.wr       = w_in_fire && (i_opcode == OP_WRITE);
    assign w_ctl.wr_index = i_entry_index;
    assign w_ctl.wr_value = i_entry_value;
    assign w_ctl.wr_care  = i_entry_care;
    assign w_ctl.shift    = w_fire_data;
    assign w_ctl.flush    = r_flush;
    assign w_ctl.data     = i_data_byte;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic w_prev;
        if (k == 0) begin : g_first
            assign w_prev = 1'b1;
        end else begin : g_next
            assign w_prev = w_match[k-1];
        end
        wbps_cell #(
            .K  (k),
            .LW (LW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_len_m1 (w_len_m1),
            .i_prev   (w_prev),
            .o_match  (w_match[k])
        );
    end

    // Byte offset and the lazy clear of the match bits. A start item or a last
    // byte marks the row stale; the next byte rebuilds it from zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_flush <= 1'b1;
        end else if (w_fire_start) begin
            r_pos   <= '0;
            r_flush <= 1'b1;
        end else if (w_fire_data) begin
            r_flush <= i_data_last;
            if (i_data_last) begin
                r_pos <= '0;
            end else if (r_pos != POS_MAX) begin
                r_pos <= r_pos + OFFSET_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_fire_data) begin
            r_s1_valid <= 1'b1;
        end else if (w_s2_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire_data) begin
            r_s1_last   <= i_data_last;
            r_s1_len_m1 <= w_len_m1;
            r_s1_pos    <= r_pos;
        end
    end

    // ----------------------------------------------------------- qualify stage
    assign w_s2_go  = r_s1_valid && !(r_s1_last && w_skid_full);
    assign w_hit    = w_match[r_s1_len_m1];
    assign w_pos_w  = W'(r_s1_pos);
    assign w_len_w  = W'(r_s1_len_m1);
    assign w_mstart = w_pos_w - w_len_w;

    assign w_cand = w_hit && !r_seen && (w_pos_w >= w_len_w)
                 && (w_mstart >= W'(r_cfg_start))
                 && ((r_cfg_end == '0) || (w_mstart < W'(r_cfg_end)));

    // Range fits when the end bound does not pass the stream length.
    assign w_rok = (r_cfg_end == '0) || ((W'(r_cfg_end) - W'(1)) <= w_pos_w);

    assign w_off_w          = r_seen ? W'(r_first) : w_mstart;
    assign w_res.found      = w_rok && (r_seen || w_cand);
    assign w_res.match_offset = w_res.found ? w_off_w[OFFSET_O_W-1:0] : '0;
    assign w_res.range_ok   = w_rok;

    // A start item arriving with the qualify step clears after it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (w_fire_start) begin
            r_seen <= 1'b0;
        end else if (w_s2_go) begin
            if (r_s1_last) begin
                r_seen <= 1'b0;
            end else if (w_cand) begin
                r_seen <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_go && !r_s1_last && w_cand) begin
            r_first <= w_mstart[OFFSET_BITS-1:0];
        end
    end

    // ---------------------------------------------------------- result buffer
    wbps_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_s2_go && r_s1_last),
        .i_data      (w_res),
        .o_skid_full (w_skid_full),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_data      (w_out)
    );

    assign o_found        = w_out.found;
    assign o_match_offset = w_out.match_offset;
    assign o_range_ok     = w_out.range_ok;

    // ------------------------------------------------------------- assertions
    a_last_clears_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire_data && i_data_last) |=> (r_pos == '0) && r_flush)
        else $error("offset not cleared after last byte");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire_start |=> (!r_seen && r_flush && (r_pos == '0)))
        else $error("search state not cleared by start");

    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> o_range_ok)
        else $error("match reported outside a valid range");

    a_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_match_offset == '0))
        else $error("nonzero offset without a match");

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_skid_full |-> o_out_valid)
        else $error("skid entry held with empty output register");

endmodule : wildcard_byte_pattern_search

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the wildcard byte pattern search block.
`timescale 1ns / 1ps

module tb_top;
    import wbps_pkg::*;

    localparam int MAX_LEN        = 256;
    localparam int ITEM_TARGET    = 1250;
    localparam int SETTLE_CYCLES  = 6;
    localparam int DRAIN_LIMIT    = 4000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int PRINT_LIMIT    = 50;
    localparam int TIMEOUT_NS     = 2_000_000;

    // Fourth opcode: the block drops it.
    localparam logic [1:0] OP_IGNORED = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] index;
        logic [7:0] value;
        logic       care;
        logic [7:0] data;
        logic       last;
    } t_scan_item;

    typedef struct packed {
        logic [LEN_CFG_W-1:0] len;
        logic [RANGE_W-1:0]   rstart;
        logic [RANGE_W-1:0]   rend;
    } t_cfg_set;

    // Directed rows: a plain item, an item with its result written out, or a register set.
    typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        t_scan_item item;
        t_cfg_set   cfg;
        t_result    res;
    } t_dir_row;

    localparam t_scan_item NO_ITEM = '0;
    localparam t_cfg_set   NO_CFG  = '0;
    localparam t_result    NO_RES  = '0;

    // ---------------------------------------------------------------------
    // DUT ports
    // ---------------------------------------------------------------------
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr     = '0;
    logic [RANGE_W-1:0]    i_cfg_wdata    = '0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic [1:0]            i_opcode       = OP_WRITE;
    logic [BYTE_W-1:0]     i_entry_index  = '0;
    logic [BYTE_W-1:0]     i_entry_value  = '0;
    logic                  i_entry_care   = 1'b0;
    logic [BYTE_W-1:0]     i_data_byte    = '0;
    logic                  i_data_last    = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic                  o_found;
    logic [OFFSET_O_W-1:0] o_match_offset;
    logic                  o_range_ok;

    // Rides along with the input payload: a hand-written result for directed rows.
    logic                  cur_typed      = 1'b0;
    t_result               cur_want       = '0;

    wildcard_byte_pattern_search dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .i_entry_care   (i_entry_care),
        .i_data_byte    (i_data_byte),
        .i_data_last    (i_data_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_found        (o_found),
        .o_match_offset (o_match_offset),
        .o_range_ok     (o_range_ok)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Search predictor: its own copy of the pattern, match chain and registers
    // ---------------------------------------------------------------------
    logic [8:0]            pat_store [MAX_LEN];     // {care, byte}
    bit   [MAX_LEN:0]      part_bits    = '0;       // bit k: first k positions matched
    logic [OFFSET_O_W-1:0] byte_pos     = '0;
    logic [OFFSET_O_W-1:0] first_off    = '0;
    bit                    match_seen   = 1'b0;
    logic [LEN_CFG_W-1:0]  cfg_len      = 9'd1;
    logic [RANGE_W-1:0]    cfg_rstart   = '0;
    logic [RANGE_W-1:0]    cfg_rend     = '0;

    t_result pending_results [$];   // expected results, oldest first
    int      mismatch_count = 0;
    int      items_sent     = 0;

    // Stimulus side view of the pattern, used to plant matches in streams.
    logic [8:0] stim_pat     [MAX_LEN];
    bit         stim_written [MAX_LEN];

    int in_idle_pct  = 9;
    int out_idle_pct = 9;
    bit rx_hold_req  = 1'b0;

    function automatic void clear_scan();
        part_bits  = '0;
        byte_pos   = '0;
        first_off  = '0;
        match_seen = 1'b0;
    endfunction

    // Advances the search by one transfer; returns 1 when a result is due.
    function automatic bit scan_step(input t_scan_item it, output t_result res);
        int unsigned     len;
        int              k;
        longint unsigned pos, s;
        logic [8:0]      e;
        bit              ok, prevb, rok;
        res = '0;
        case (it.opcode)
            OP_WRITE: begin
                pat_store[it.index] = {it.care, it.value};
                return 1'b0;
            end
            OP_START: begin
                clear_scan();
                return 1'b0;
            end
            OP_DATA: ;
            default: return 1'b0;
        endcase

        // zero length counts as one, oversize saturates
        len = (cfg_len == 0) ? 1 : (cfg_len > MAX_LEN) ? MAX_LEN : cfg_len;
        pos = byte_pos;
        // walk from the deep end so each cell sees the previous byte's bit
        for (k = int'(len) - 1; k >= 0; k--) begin
            e          = pat_store[k];
            ok         = !e[8] || (e[7:0] == it.data);
            prevb      = (k == 0) ? 1'b1 : part_bits[k];
            part_bits[k+1] = prevb && ok;
        end

        if (part_bits[len] && !match_seen && pos >= len - 1) begin
            s = pos - (len - 1);
            if (s >= cfg_rstart && (cfg_rend == 0 || s < cfg_rend)) begin
                match_seen = 1'b1;
                first_off  = s[OFFSET_O_W-1:0];
            end
        end

        if (byte_pos != '1)
            byte_pos++;

        if (!it.last)
            return 1'b0;

        // range end must not lie past the stream length (pos + 1)
        rok              = (cfg_rend == 0) || (cfg_rend - 1 <= pos);
        res.found        = rok && match_seen;
        res.match_offset = res.found ? first_off : '0;
        res.range_ok     = rok;
        clear_scan();
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------------
    // Transfer monitor and result check
    // ---------------------------------------------------------------------
    task automatic report(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t mismatch: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin : monitor
        t_scan_item cur;
        t_result    r, want;
        bit         due;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report("result transfer with nothing expected");
                end else begin
                    want = pending_results.pop_front();
                    if (o_found !== want.found)
                        report($sformatf("found %0b, want %0b", o_found, want.found));
                    if (o_match_offset !== want.match_offset)
                        report($sformatf("match_offset %h, want %h",
                                         o_match_offset, want.match_offset));
                    if (o_range_ok !== want.range_ok)
                        report($sformatf("range_ok %0b, want %0b", o_range_ok, want.range_ok));
                end
            end
            if (i_in_valid && o_in_ready) begin
                cur = {i_opcode, i_entry_index, i_entry_value, i_entry_care,
                       i_data_byte, i_data_last};
                due = scan_step(cur, r);
                if (due)
                    pending_results.insert(pending_results.size(), cur_typed ? cur_want : r);
            end
        end
    end

    // Receiver: random stalls, or one long hold-off when asked for.
    always @(posedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            i_out_ready <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(posedge i_clk);
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
        end
    end

    // ---------------------------------------------------------------------
    // Item builders: fields the opcode does not use carry random bits
    // ---------------------------------------------------------------------
    function automatic t_scan_item ctl_item(input logic [1:0] op);
        logic [31:0] rnd;
        t_scan_item  it;
        rnd       = $urandom;
        it        = rnd[$bits(t_scan_item)-1:0];
        it.opcode = op;
        return it;
    endfunction

    function automatic t_scan_item data_item(input logic [7:0] b, input logic l);
        t_scan_item it;
        it      = ctl_item(OP_DATA);
        it.data = b;
        it.last = l;
        return it;
    endfunction

    function automatic t_scan_item write_item(input logic [7:0] idx, input logic [7:0] v,
                                              input logic c);
        t_scan_item it;
        it       = ctl_item(OP_WRITE);
        it.index = idx;
        it.value = v;
        it.care  = c;
        return it;
    endfunction

    // ---------------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------------
    // Called at a rising edge; returns at the edge of the transfer, valid still high.
    task automatic send_item(input t_scan_item it, input bit typed = 1'b0,
                             input t_result want = '0);
        if ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < in_idle_pct);
        end
        i_opcode      <= it.opcode;
        i_entry_index <= it.index;
        i_entry_value <= it.value;
        i_entry_care  <= it.care;
        i_data_byte   <= it.data;
        i_data_last   <= it.last;
        cur_typed     <= typed;
        cur_want      <= want;
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (it.opcode == OP_WRITE) begin
            stim_pat[it.index]     = {it.care, it.value};
            stim_written[it.index] = 1'b1;
        end
        if (it.opcode != OP_IGNORED)
            items_sent++;
    endtask

    // Registers only change with nothing in flight.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_apply(input t_cfg_set c);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_LEN;
        i_cfg_wdata <= RANGE_W'(c.len);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_START;
        i_cfg_wdata <= c.rstart;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_END;
        i_cfg_wdata <= c.rend;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_len    = c.len;
        cfg_rstart = c.rstart;
        cfg_rend   = c.rend;
    endtask

    // One phase: registers, pattern, then a stream with the pattern planted in it up to twice.
    task automatic random_phase(input int ph);
        int         len_sel, n, p, j, k, r, pick;
        bit         open_end;
        t_cfg_set   c;
        logic [7:0] alpha [4];
        logic [7:0] stream [512];
        wait_idle();

        r = $urandom_range(0, 99);
        if (ph == 5 || (ph == 30 && items_sent < ITEM_TARGET - 600))
            len_sel = MAX_LEN;
        else if (r < 55)
            len_sel = $urandom_range(1, 4);
        else if (r < 88)
            len_sel = $urandom_range(5, 16);
        else
            len_sel = $urandom_range(17, 48);

        c.len = LEN_CFG_W'(len_sel);
        if (len_sel == 1 && $urandom_range(0, 2) == 0)
            c.len = '0;                                     // zero reads as one
        if (len_sel == MAX_LEN && $urandom_range(0, 1) == 1)
            c.len = LEN_CFG_W'($urandom_range(MAX_LEN + 1, 511));  // saturates

        n = len_sel - 1 + $urandom_range(1, 24);
        if ($urandom_range(0, 9) == 0)
            n = $urandom_range(1, len_sel);                 // match may not fit

        // start bound / end bound, extremes included
        c.rstart = '0;
        c.rend   = '0;
        r = $urandom_range(0, 99);
        if (r < 35) begin
        end else if (r < 55) begin
            c.rstart = RANGE_W'($urandom_range(0, n));
        end else if (r < 85) begin
            c.rstart = RANGE_W'($urandom_range(0, n));
            c.rend   = RANGE_W'($urandom_range(1, n + 3));
        end else if (r < 90) begin
            c.rstart = '1;
        end else if (r < 95) begin
            c.rend = '1;
        end else begin
            c.rstart = $urandom;
            c.rend   = $urandom;
        end
        cfg_apply(c);

        // every entry in use is written before any byte reads it
        for (j = 0; j < len_sel; j++)
            if (!stim_written[j] ||
                $urandom_range(0, (len_sel == MAX_LEN) ? 15 : 3) == 0)
                send_item(write_item(8'(j), 8'($urandom), ($urandom_range(0, 9) < 7)));

        // small alphabet taken from the pattern keeps partial matches frequent
        for (k = 0; k < 4; k++) begin
            pick     = $urandom_range(0, len_sel - 1);
            alpha[k] = stim_pat[pick][7:0];
        end
        for (j = 0; j < n; j++)
            stream[j] = ($urandom_range(0, 3) != 0) ? alpha[$urandom_range(0, 3)]
                                                    : 8'($urandom);
        if (n >= len_sel)
            repeat ($urandom_range(0, 2)) begin
                p = $urandom_range(0, n - len_sel);
                for (k = 0; k < len_sel; k++)
                    if (stim_pat[k][8])
                        stream[p + k] = stim_pat[k][7:0];
            end

        // now and then the stream runs on into the next phase
        open_end = ($urandom_range(0, 11) == 0);
        if ($urandom_range(0, 9) != 0)
            send_item(ctl_item(OP_START));
        for (j = 0; j < n; j++) begin
            if ($urandom_range(0, 49) == 0)
                send_item(ctl_item(OP_IGNORED));
            if ($urandom_range(0, 99) == 0)
                send_item(write_item(8'($urandom), 8'($urandom), 1'($urandom)));
            send_item(data_item(stream[j], (j == n - 1) && !open_end));
        end
    endtask

    // ---------------------------------------------------------------------
    // Directed table
    // ---------------------------------------------------------------------
    localparam int DIR_ROWS = 31;
    t_dir_row dir_rows [DIR_ROWS] = '{
        // single entry after reset: length 1, range 0..end of stream
        '{ROW_ITEM,  '{OP_WRITE,   8'h00, 8'hFF, 1'b1, 8'h00, 1'b0}, NO_CFG, NO_RES},
        '{ROW_TYPED, '{OP_DATA,    8'h00, 8'h00, 1'b0, 8'hFF, 1'b1}, NO_CFG,
                     '{1'b1, 32'd0, 1'b1}},
        '{ROW_TYPED, '{OP_DATA,    8'h00, 8'h00, 1'b0, 8'h00, 1'b1}, NO_CFG,
                     '{1'b0, 32'd0, 1'b1}},
        '{ROW_ITEM,  '{OP_WRITE,   8'hFF, 8'h00, 1'b0, 8'h00, 1'b0}, NO_CFG, NO_RES},
        // dropped opcode with every field at its top
        '{ROW_ITEM,  '{OP_IGNORED, 8'hFF, 8'hFF, 1'b1, 8'hFF, 1'b1}, NO_CFG, NO_RES},
        '{ROW_ITEM,  '{OP_WRITE,   8'h00, 8'h00, 1'b1, 8'h00, 1'b0}, NO_CFG, NO_RES},
        // zero length behaves as one
        '{ROW_CFG,   NO_ITEM, '{9'd0, 32'd0, 32'd0}, NO_RES},
        '{ROW_TYPED, '{OP_DATA,    8'h00, 8'h00, 1'b0, 8'h00, 1'b1}, NO_CFG,
                     '{1'b1, 32'd0, 1'b1}},
        // three-entry pattern with a trailing wildcard
        '{ROW_ITEM,  '{OP_WRITE,   8'h00, 8'hAA, 1'b1, 8'h00, 1'b0}, NO_CFG, NO_RES},
        '{ROW_ITEM,  '{OP_WRITE,   8'h01, 8'h55, 1'b1, 8'h00, 1'b0}, NO_CFG, NO_RES},
        '{ROW_ITEM,  '{OP_WRITE,   8'h02, 8'h12, 1'b0, 8'h00, 1'b0}, NO_CFG, NO_RES},
        '{ROW_CFG,   NO_ITEM, '{9'd3, 32'd0, 32'd0}, NO_RES},
        // start in mid-stream throws away the partial match
        '{ROW_ITEM,  '{OP_DATA,    8'h00, 8'h00, 1'b0, 8'hAA, 1'b0}, NO_CFG, NO_RES},
        '{ROW_ITEM,  '{OP_DATA,    8'h00, 8'h00, 1'b0, 8'h55, 1'b0}, NO_CFG, NO_RES},
        '{ROW_ITEM,  '{OP_START,   8'h00, 8'h00, 1'b0, 8'h00, 1'b0}, NO_CFG, NO_RES},
        '{ROW_ITEM,  '{OP_DATA,    8'h00, 8'h00, 1'b0, 8'h00, 1'b0}, NO_CFG, NO_RES},
        '{ROW_ITEM,  '{OP_DATA,    8'h00, 8'h00, 1'b0, 8'hAA, 1'b0}, NO_CFG, NO_RES},
        '{ROW_ITEM,  '{OP_DATA,    8'h00, 8'h00, 1'b0, 8'h55, 1'b0}, NO_CFG, NO_RES},
        '{ROW_ITEM,  '{OP_DATA,    8'h00, 8'h00, 1'b0, 8'h77, 1'b1}, NO_CFG, NO_RES},
        // range window skips the first of two matches
        '{ROW_CFG,   NO_ITEM, '{9'd3, 32'd2, 32'd5}, NO_RES},
        '{ROW_ITEM,  '{OP_DATA,    8'h00, 8'h00, 1'b0, 8'hAA, 1'b0}, NO_CFG, NO_RES},
        '{ROW_ITEM,  '{OP_DATA,    8'h00, 8'h00, 1'b0, 8'h55, 1'b0}, NO_CFG, NO_RES},
        '{ROW_ITEM,  '{OP_DATA,    8'h00, 8'h00, 1'b0, 8'h00, 1'b0}, NO_CFG, NO_RES},
        '{ROW_ITEM,  '{OP_DATA,    8'h00, 8'h00, 1'b0, 8'hAA, 1'b0}, NO_CFG, NO_RES},
        '{ROW_ITEM,  '{OP_DATA,    8'h00, 8'h00, 1'b0, 8'h55, 1'b0}, NO_CFG, NO_RES},
        '{ROW_ITEM,  '{OP_DATA,    8'h00, 8'h00, 1'b0, 8'h00, 1'b1}, NO_CFG, NO_RES},
        // end bound past the stream: range not ok
        '{ROW_CFG,   NO_ITEM, '{9'd3, 32'd0, 32'hFFFF_FFFF}, NO_RES},
        '{ROW_TYPED, '{OP_DATA,    8'h00, 8'h00, 1'b0, 8'h00, 1'b1}, NO_CFG,
                     '{1'b0, 32'd0, 1'b0}},
        // top start bound; match would also run past the last byte
        '{ROW_CFG,   NO_ITEM, '{9'd3, 32'hFFFF_FFFF, 32'd0}, NO_RES},
        '{ROW_ITEM,  '{OP_DATA,    8'h00, 8'h00, 1'b0, 8'hAA, 1'b0}, NO_CFG, NO_RES},
        '{ROW_ITEM,  '{OP_DATA,    8'h00, 8'h00, 1'b0, 8'h55, 1'b1}, NO_CFG, NO_RES}
    };

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin : stimulus
        int ph;
        int drain;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_CFG: begin
                    wait_idle();
                    cfg_apply(dir_rows[i].cfg);
                end
                ROW_TYPED: send_item(dir_rows[i].item, 1'b1, dir_rows[i].res);
                default:   send_item(dir_rows[i].item);
            endcase
        end

        // Back-pressure: receiver holds off while short streams keep coming,
        // so the result buffer fills and the input stalls.
        wait_idle();
        cfg_apply('{9'd1, 32'd0, 32'd0});
        send_item(write_item(8'h00, 8'h3C, 1'b1));
        in_idle_pct = 0;
        rx_hold_req = 1'b1;
        repeat (40) begin
            repeat ($urandom_range(0, 2))
                send_item(data_item(8'($urandom), 1'b0));
            send_item(data_item(($urandom_range(0, 1) == 1) ? 8'h3C : 8'($urandom), 1'b1));
        end
        in_idle_pct = 9;

        ph = 0;
        while (items_sent < ITEM_TARGET) begin
            // a stretch of phases with neither side idling
            in_idle_pct  = (ph >= 8 && ph < 13) ? 0 : 9;
            out_idle_pct = (ph >= 8 && ph < 13) ? 0 : 9;
            random_phase(ph);
            ph++;
        end
        out_idle_pct = 9;

        i_in_valid <= 1'b0;
        drain = 0;
        @(posedge i_clk);
        while (pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report($sformatf("%0d expected results never arrived", pending_results.size()));

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
